[design/ffha_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ffha_pkg;

  localparam int HEAP_UNITS   = 131072;
  localparam int HEADER_BYTES = 16;
  localparam int HDR_UNITS    = (HEADER_BYTES + 3) / 4;

  // unit offset, heap top and walk sums
  localparam int UNIT_W = $clog2(HEAP_UNITS);
  localparam int TOP_W  = UNIT_W + 1;
  localparam int NXT_W  = TOP_W + 1;
  localparam int SIZE_W = TOP_W;
  localparam int REQ_W  = 20;
  localparam int R_W    = REQ_W - 1;
  localparam int NEED_W = (R_W > TOP_W ? R_W : TOP_W) + 1;

  localparam logic [31:0] HEAP_START_RST = 32'h0000_8000;
  localparam logic [31:0] HEAP_END_RST   = 32'h0008_0000;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OOM     = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic CFG_HEAP_START = 1'b0;
  localparam logic CFG_HEAP_END   = 1'b1;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [UNIT_W-1:0] prev;
    logic              free;
  } hdr_t;

  localparam int HDR_W = $bits(hdr_t);

  typedef struct packed {
    logic              re;
    logic [UNIT_W-1:0] raddr;
    logic              we;
    logic [UNIT_W-1:0] waddr;
    hdr_t              wdata;
  } ram_req_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  status;
    logic [31:0] addr;
  } res_t;

endpackage
`default_nettype wire

[design/ffha_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module ffha_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[design/ffha_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module ffha_ctrl (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic                    cmd_i,
  input  wire logic [ffha_pkg::REQ_W-1:0] req_i,
  input  wire logic [31:0]             addr_i,
  input  wire logic [31:0]             heap_start_i,
  input  wire logic [31:0]             heap_end_i,
  output ffha_pkg::ram_req_t           ram_o,
  input  wire ffha_pkg::hdr_t          rdata_i,
  output ffha_pkg::res_t               res_o,
  input  wire logic                    res_ready_i
);

  localparam int UW = ffha_pkg::UNIT_W;
  localparam int TW = ffha_pkg::TOP_W;
  localparam int NW = ffha_pkg::NXT_W;
  localparam int SW = ffha_pkg::SIZE_W;
  localparam int RW = ffha_pkg::R_W;
  localparam int EW = ffha_pkg::NEED_W;
  localparam logic [NW-1:0] HDR_N = NW'(ffha_pkg::HDR_UNITS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_AREAD = 4'd1;
  localparam logic [3:0] S_AUSE  = 4'd2;
  localparam logic [3:0] S_ASPL  = 4'd3;
  localparam logic [3:0] S_AEXT  = 4'd4;
  localparam logic [3:0] S_FCHK  = 4'd5;
  localparam logic [3:0] S_FNXT  = 4'd6;
  localparam logic [3:0] S_FTGT  = 4'd7;
  localparam logic [3:0] S_FFCHK = 4'd8;
  localparam logic [3:0] S_FFUSE = 4'd9;
  localparam logic [3:0] S_FBCHK = 4'd10;
  localparam logic [3:0] S_FBUSE = 4'd11;
  localparam logic [3:0] S_FWRU  = 4'd12;
  localparam logic [3:0] S_FIX   = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0]    state_q, state_d;
  logic [TW-1:0] top_q, top_d;
  logic          nonempty_q, nonempty_d;

  logic [RW-1:0] r_q, r_d;
  logic [UW-1:0] target_q, target_d;
  logic [NW-1:0] u_q, u_d;
  logic [NW-1:0] n_q, n_d;
  logic [UW-1:0] last_q, last_d;
  logic          have_last_q, have_last_d;
  logic [UW-1:0] fix_prev_q, fix_prev_d;
  ffha_pkg::hdr_t cur_q, cur_d;
  logic [1:0]    status_q, status_d;
  logic [31:0]   raddr_q, raddr_d;

  // free address decode
  logic [31:0]   off;
  logic [29:0]   du, du_m4;
  logic          bad_free;
  // walk arithmetic
  logic [NW-1:0] u_next, top_n, split_nb, n_cur;
  logic [RW:0]   spare;
  logic          fit;
  logic [EW-1:0] need;
  logic [33:0]   need_end;
  logic          ext_fail;
  logic [31:0]   daddr_u, daddr_top;
  logic [SW-1:0] fwd_size, bwd_size;

  assign off      = addr_i - heap_start_i;
  assign du       = off[31:2];
  assign du_m4    = du - 30'(ffha_pkg::HDR_UNITS);
  assign bad_free = (addr_i < heap_start_i) || (off[1:0] != 2'b00) ||
                    (du < 30'(ffha_pkg::HDR_UNITS)) || (du_m4 >= 30'(top_q));

  assign top_n     = NW'(top_q);
  assign u_next    = u_q + HDR_N + NW'(rdata_i.size);
  assign spare     = {1'b0, rdata_i.size} - {1'b0, r_q};
  assign fit       = rdata_i.free && ({1'b0, rdata_i.size} >= {1'b0, r_q});
  assign split_nb  = u_q + HDR_N + NW'(r_q);
  assign n_cur     = u_q + HDR_N + NW'(cur_q.size);
  assign need      = EW'(top_q) + EW'(ffha_pkg::HDR_UNITS) + EW'(r_q);
  assign need_end  = {2'b00, heap_start_i} + {(34 - EW - 2)'(0), need, 2'b00};
  assign ext_fail  = (need > EW'(ffha_pkg::HEAP_UNITS)) || (need_end > {2'b00, heap_end_i});
  assign daddr_u   = heap_start_i + {(32 - NW - 2)'(0), u_q + HDR_N, 2'b00};
  assign daddr_top = heap_start_i + {(32 - NW - 2)'(0), top_n + HDR_N, 2'b00};
  assign fwd_size  = cur_q.size + SW'(ffha_pkg::HDR_UNITS) + rdata_i.size;
  assign bwd_size  = rdata_i.size + SW'(ffha_pkg::HDR_UNITS) + cur_q.size;

  assign in_ready_o   = (state_q == S_IDLE);
  assign res_o.valid  = (state_q == S_DONE);
  assign res_o.status = status_q;
  assign res_o.addr   = raddr_q;

  // sequence the header reads and writes of one transaction
  always_comb begin
    state_d     = state_q;
    top_d       = top_q;
    nonempty_d  = nonempty_q;
    r_d         = r_q;
    target_d    = target_q;
    u_d         = u_q;
    n_d         = n_q;
    last_d      = last_q;
    have_last_d = have_last_q;
    fix_prev_d  = fix_prev_q;
    cur_d       = cur_q;
    status_d    = status_q;
    raddr_d     = raddr_q;
    ram_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          r_d         = RW'(({1'b0, req_i} + 21'd3) >> 2);
          target_d    = du_m4[UW-1:0];
          u_d         = '0;
          have_last_d = 1'b0;
          status_d    = ffha_pkg::ST_OK;
          raddr_d     = '0;
          if (cmd_i == ffha_pkg::CMD_ALLOC) begin
            state_d = nonempty_q ? S_AREAD : S_AEXT;
          end else if (bad_free) begin
            status_d = ffha_pkg::ST_INVALID;
            state_d  = S_DONE;
          end else begin
            state_d = S_FCHK;
          end
        end
      end
      S_AREAD: begin
        ram_o.re    = 1'b1;
        ram_o.raddr = u_q[UW-1:0];
        state_d     = S_AUSE;
      end
      S_AUSE: begin
        if (fit) begin
          raddr_d = daddr_u;
          if (spare >= (RW+1)'(ffha_pkg::HDR_UNITS + 1)) begin
            ram_o.we         = 1'b1;
            ram_o.waddr      = split_nb[UW-1:0];
            ram_o.wdata.size = SW'(spare - (RW+1)'(ffha_pkg::HDR_UNITS));
            ram_o.wdata.prev = u_q[UW-1:0];
            ram_o.wdata.free = 1'b1;
            cur_d.size       = SW'(r_q);
            cur_d.prev       = rdata_i.prev;
            cur_d.free       = 1'b0;
            n_d              = u_next;
            fix_prev_d       = split_nb[UW-1:0];
            state_d          = S_ASPL;
          end else begin
            ram_o.we    = 1'b1;
            ram_o.waddr = u_q[UW-1:0];
            ram_o.wdata = '{size: rdata_i.size, prev: rdata_i.prev, free: 1'b0};
            state_d     = S_DONE;
          end
        end else begin
          last_d      = u_q[UW-1:0];
          have_last_d = 1'b1;
          u_d         = u_next;
          state_d     = (u_next < top_n) ? S_AREAD : S_AEXT;
        end
      end
      S_ASPL: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = u_q[UW-1:0];
        ram_o.wdata = cur_q;
        if (n_q < top_n) begin
          ram_o.re    = 1'b1;
          ram_o.raddr = n_q[UW-1:0];
          state_d     = S_FIX;
        end else begin
          state_d = S_DONE;
        end
      end
      S_AEXT: begin
        if (ext_fail) begin
          status_d = ffha_pkg::ST_OOM;
          raddr_d  = '0;
        end else begin
          ram_o.we         = 1'b1;
          ram_o.waddr      = top_q[UW-1:0];
          ram_o.wdata.size = SW'(r_q);
          ram_o.wdata.prev = have_last_q ? last_q : '0;
          ram_o.wdata.free = 1'b0;
          top_d            = TW'(need);
          nonempty_d       = 1'b1;
          raddr_d          = daddr_top;
        end
        state_d = S_DONE;
      end
      S_FCHK: begin
        if (u_q == NW'(target_q)) begin
          ram_o.re    = 1'b1;
          ram_o.raddr = target_q;
          state_d     = S_FTGT;
        end else if ((u_q > NW'(target_q)) || (u_q >= top_n)) begin
          status_d = ffha_pkg::ST_INVALID;
          state_d  = S_DONE;
        end else begin
          ram_o.re    = 1'b1;
          ram_o.raddr = u_q[UW-1:0];
          state_d     = S_FNXT;
        end
      end
      S_FNXT: begin
        u_d     = u_next;
        state_d = S_FCHK;
      end
      S_FTGT: begin
        if (rdata_i.free) begin
          status_d = ffha_pkg::ST_INVALID;
          state_d  = S_DONE;
        end else begin
          cur_d   = '{size: rdata_i.size, prev: rdata_i.prev, free: 1'b1};
          n_d     = u_next;
          state_d = S_FFCHK;
        end
      end
      S_FFCHK: begin
        if (n_q < top_n) begin
          ram_o.re    = 1'b1;
          ram_o.raddr = n_q[UW-1:0];
          state_d     = S_FFUSE;
        end else begin
          state_d = S_FBCHK;
        end
      end
      S_FFUSE: begin
        if (rdata_i.free) begin
          cur_d.size = fwd_size;
          n_d        = u_q + HDR_N + NW'(fwd_size);
          state_d    = S_FFCHK;
        end else begin
          state_d = S_FBCHK;
        end
      end
      S_FBCHK: begin
        if (u_q == '0) begin
          state_d = S_FWRU;
        end else begin
          ram_o.re    = 1'b1;
          ram_o.raddr = cur_q.prev;
          state_d     = S_FBUSE;
        end
      end
      S_FBUSE: begin
        if (rdata_i.free) begin
          cur_d   = '{size: bwd_size, prev: rdata_i.prev, free: 1'b1};
          u_d     = NW'(cur_q.prev);
          state_d = S_FBCHK;
        end else begin
          state_d = S_FWRU;
        end
      end
      S_FWRU: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = u_q[UW-1:0];
        ram_o.wdata = cur_q;
        n_d         = n_cur;
        fix_prev_d  = u_q[UW-1:0];
        if (n_cur < top_n) begin
          ram_o.re    = 1'b1;
          ram_o.raddr = n_cur[UW-1:0];
          state_d     = S_FIX;
        end else begin
          state_d = S_DONE;
        end
      end
      S_FIX: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = n_q[UW-1:0];
        ram_o.wdata = '{size: rdata_i.size, prev: fix_prev_q, free: rdata_i.free};
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      top_q      <= '0;
      nonempty_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      top_q      <= top_d;
      nonempty_q <= nonempty_d;
    end
  end

  // hold walk and result payload
  always_ff @(posedge clk_i) begin
    r_q         <= r_d;
    target_q    <= target_d;
    u_q         <= u_d;
    n_q         <= n_d;
    last_q      <= last_d;
    have_last_q <= have_last_d;
    fix_prev_q  <= fix_prev_d;
    cur_q       <= cur_d;
    status_q    <= status_d;
    raddr_q     <= raddr_d;
  end

endmodule
`default_nettype wire

[design/first_fit_heap_allocator_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// First-fit heap allocator: one command per input transaction (tuser = 0 allocate,
// 1 free), one result per command (tuser status: 0 ok, 1 out of memory, 2 invalid
// free; tdata data address, 0 when none). Block headers live in a single-port-read
// header memory with a registered read, so the address-ordered block walk issues
// each header read in its own state before it uses the data. An allocate takes a
// free block whole, splits one (then fixing the prev link of the block after it, if
// any), extends the heap top or fails. A free walks the blocks ahead of the freed one
// and merges it with free neighbors on both sides; a rejected address is caught by
// the decode or by the walk. One command is in work at a time; the next one is
// accepted while the previous result waits in the output register. Reset needs no
// memory sweep.
module first_fit_heap_allocator_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,  // [19:0] request_bytes, [51:20] free_address
  input  wire logic        s_axis_tuser,  // [0] command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // [31:0] data_address
  output logic [1:0]       m_axis_tuser,  // [1:0] status
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  logic [31:0] heap_start_q, heap_end_q;
  logic        out_valid_q;
  logic [1:0]  out_status_q;
  logic [31:0] out_addr_q;
  logic        res_ready;

  ffha_pkg::ram_req_t ram_req;
  ffha_pkg::hdr_t     ram_rdata;
  ffha_pkg::res_t     res;

  // take register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_start_q <= ffha_pkg::HEAP_START_RST;
      heap_end_q   <= ffha_pkg::HEAP_END_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ffha_pkg::CFG_HEAP_START: heap_start_q <= cfg_data_i;
        ffha_pkg::CFG_HEAP_END:   heap_end_q   <= cfg_data_i;
        default:                  heap_end_q   <= heap_end_q;
      endcase
    end
  end

  ffha_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .cmd_i        (s_axis_tuser),
    .req_i        (s_axis_tdata[19:0]),
    .addr_i       (s_axis_tdata[51:20]),
    .heap_start_i (heap_start_q),
    .heap_end_i   (heap_end_q),
    .ram_o        (ram_req),
    .rdata_i      (ram_rdata),
    .res_o        (res),
    .res_ready_i  (res_ready)
  );

  ffha_ram #(
    .DEPTH (ffha_pkg::HEAP_UNITS),
    .WIDTH (ffha_pkg::HDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .rdata_o (ram_rdata)
  );

  // hold the result until the output transaction completes
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) begin
      out_status_q <= res.status;
      out_addr_q   <= res.addr;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_addr_q;
  assign m_axis_tuser  = out_status_q;

endmodule
`default_nettype wire
